### rtl/core/esp3_packet_receiver_top_macros.svh
// Assertion macros for the ESP3 packet receiver.
// All checks run on clk and are off while rst_n is low.
`ifndef ESP3_PACKET_RECEIVER_TOP_MACROS_SVH
`define ESP3_PACKET_RECEIVER_TOP_MACROS_SVH

// Property that must hold at every clock edge.
`define ESP3_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequence that must hold in the cycle after the trigger.
`define ESP3_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/esp3_rx_pkg.sv
package esp3_rx_pkg;

    // Framing constants
    localparam logic [7:0] SYNC_CODE = 8'h55;
    localparam logic [7:0] CRC_POLY  = 8'h07;
    localparam int         HDR_LEN   = 4;
    localparam int         COUNT_W   = 17;
    localparam logic [15:0] CAP_RESET = 16'd256;

    // Receiver phase, one-hot
    typedef enum logic [4:0] {
        PH_SYNC   = 5'b00001,
        PH_HEADER = 5'b00010,
        PH_HCRC   = 5'b00100,
        PH_DATA   = 5'b01000,
        PH_DCRC   = 5'b10000
    } phase_t;

    // Reported status codes
    typedef enum logic [2:0] {
        ST_HUNT   = 3'd0,
        ST_BUSY   = 3'd1,
        ST_OK     = 3'd2,
        ST_RANGE  = 3'd3,
        ST_BADSUM = 3'd4
    } status_t;

    // Result item, laid out as it appears on m_tdata (status in the low bits)
    typedef struct packed {
        logic [3:0]  pad;
        logic [7:0]  packet_type;
        logic [7:0]  option_length;
        logic [15:0] data_length;
        logic [15:0] stored_index;
        logic [7:0]  stored_byte;
        logic        stored_valid;
        status_t     status;
    } result_t;

    typedef logic [7:0] crc_col_t [32];

    // One byte worth of shifts of the CRC-8 register (elaboration only)
    function automatic logic [7:0] crc_shift8(logic [7:0] c_in);
        logic [7:0] c;
        c = c_in;
        for (int b = 0; b < 8; b++)
        begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // CRC of a 4-byte word with a single bit set, for every bit position.
    // Byte [31:24] goes first on the wire.
    function automatic crc_col_t crc_columns();
        crc_col_t   cols;
        logic [31:0] w;
        logic [7:0]  c;
        for (int i = 0; i < 32; i++)
        begin
            w = 32'd1 << i;
            c = 8'd0;
            for (int j = 3; j >= 0; j--)
            begin
                c = crc_shift8(c ^ w[8*j +: 8]);
            end
            cols[i] = c;
        end
        return cols;
    endfunction

    localparam crc_col_t CRC_COLS = crc_columns();

    // CRC-8 of up to four bytes from zero; leading zero bytes do not change it
    function automatic logic [7:0] crc_word(logic [31:0] w);
        logic [7:0] c;
        c = 8'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (w[i])
            begin
                c = c ^ CRC_COLS[i];
            end
        end
        return c;
    endfunction

    // Running CRC update by one byte
    function automatic logic [7:0] crc_byte(logic [7:0] crc, logic [7:0] data);
        return crc_word({24'd0, crc ^ data});
    endfunction

endpackage

### rtl/core/esp3_packet_receiver_top.sv
// Channel   | Dir | Signals                       | Item
// ----------+-----+-------------------------------+-------------------------------------
// s         | in  | s_tvalid s_tready s_tdata[7:0]  | one received serial byte
// m         | out | m_tvalid m_tready m_tdata[63:0] | status and header/payload view
// cfg       | in  | cfg_we cfg_data[15:0]           | buffer_capacity write
//
// One item per cycle unless the output stalls: each received byte is processed by one
// level of logic between the phase/header/CRC registers and the output register.
// Every input item produces exactly one output item, in the cycle after acceptance.
// s_tready is high while the output register is empty or being taken, so a
// stalled output holds one item and stops input only until it is taken.
// Reset (rst_n, async, active low) puts the receiver in sync hunt, capacity 256.
`include "esp3_packet_receiver_top_macros.svh"

module esp3_packet_receiver_top
    import esp3_rx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] status, [3] stored_valid, [11:4] stored_byte, [27:12] stored_index,
    // [43:28] data_length, [51:44] option_length, [59:52] packet_type, [63:60] zero
    output logic [63:0] m_tdata,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data   // buffer_capacity
);

    logic [15:0]        capacity_reg;
    phase_t             phase_reg, phase_next;
    logic [7:0]         hdr_reg [HDR_LEN];
    logic [7:0]         hdr_next [HDR_LEN];
    logic [7:0]         crc_reg, crc_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               m_valid_reg, m_valid_next;
    result_t            result_reg, res;

    logic               in_fire;
    logic [7:0]         rx;
    logic [COUNT_W-1:0] total;
    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] cap_ext;
    logic               st_forced;
    status_t            st_code;

    assign rx        = s_tdata;
    assign in_fire   = s_tvalid && s_tready;
    assign total     = COUNT_W'({hdr_reg[0], hdr_reg[1]}) + COUNT_W'(hdr_reg[2]);
    assign count_inc = count_reg + COUNT_W'(1);
    assign cap_ext   = COUNT_W'(capacity_reg);

    // Per-byte deframing step
    always_comb
    begin
        phase_next = phase_reg;
        hdr_next   = hdr_reg;
        crc_next   = crc_reg;
        count_next = count_reg;
        st_forced  = 1'b0;
        st_code    = ST_HUNT;
        res        = '0;

        case (phase_reg)
            PH_SYNC:
            begin
                if (rx == SYNC_CODE)
                begin
                    phase_next = PH_HEADER;
                    count_next = '0;
                    crc_next   = '0;
                end
            end
            PH_HEADER:
            begin
                hdr_next[count_reg[1:0]] = rx;
                crc_next   = crc_byte(crc_reg, rx);
                count_next = count_inc;
                if (count_inc >= COUNT_W'(HDR_LEN))
                begin
                    phase_next = PH_HCRC;
                end
            end
            PH_HCRC:
            begin
                if (crc_reg != rx)
                begin
                    // Resync on the first sync byte inside the header
                    if (hdr_reg[0] == SYNC_CODE)
                    begin
                        hdr_next[0] = hdr_reg[1];
                        hdr_next[1] = hdr_reg[2];
                        hdr_next[2] = hdr_reg[3];
                        hdr_next[3] = rx;
                        crc_next    = crc_word({hdr_reg[1], hdr_reg[2], hdr_reg[3], rx});
                        count_next  = COUNT_W'(4);
                        phase_next  = PH_HCRC;
                    end
                    else if (hdr_reg[1] == SYNC_CODE)
                    begin
                        hdr_next[0] = hdr_reg[2];
                        hdr_next[1] = hdr_reg[3];
                        hdr_next[2] = rx;
                        crc_next    = crc_word({8'd0, hdr_reg[2], hdr_reg[3], rx});
                        count_next  = COUNT_W'(3);
                        phase_next  = PH_HEADER;
                    end
                    else if (hdr_reg[2] == SYNC_CODE)
                    begin
                        hdr_next[0] = hdr_reg[3];
                        hdr_next[1] = rx;
                        crc_next    = crc_word({16'd0, hdr_reg[3], rx});
                        count_next  = COUNT_W'(2);
                        phase_next  = PH_HEADER;
                    end
                    else if (hdr_reg[3] == SYNC_CODE)
                    begin
                        hdr_next[0] = rx;
                        crc_next    = crc_byte(8'd0, rx);
                        count_next  = COUNT_W'(1);
                        phase_next  = PH_HEADER;
                    end
                    else if (rx == SYNC_CODE)
                    begin
                        phase_next = PH_HEADER;
                        count_next = '0;
                        crc_next   = '0;
                    end
                    else
                    begin
                        phase_next = PH_SYNC;
                    end
                end
                else if (total == '0)
                begin
                    // Empty packet: reject unless the header CRC byte is itself a sync code
                    if (rx == SYNC_CODE)
                    begin
                        phase_next = PH_HEADER;
                        count_next = '0;
                        crc_next   = '0;
                    end
                    else
                    begin
                        phase_next = PH_SYNC;
                        st_forced  = 1'b1;
                        st_code    = ST_RANGE;
                    end
                end
                else
                begin
                    phase_next = PH_DATA;
                    count_next = '0;
                    crc_next   = '0;
                end
            end
            PH_DATA:
            begin
                if (count_reg < cap_ext)
                begin
                    res.stored_valid = 1'b1;
                    res.stored_byte  = rx;
                    res.stored_index = count_reg[15:0];
                    crc_next         = crc_byte(crc_reg, rx);
                end
                count_next = count_inc;
                if (count_inc == total)
                begin
                    phase_next = PH_DCRC;
                end
            end
            PH_DCRC:
            begin
                phase_next = PH_SYNC;
                st_forced  = 1'b1;
                if (count_reg > cap_ext)
                begin
                    st_code = ST_RANGE;
                end
                else if (crc_reg == rx)
                begin
                    st_code = ST_OK;
                end
                else
                begin
                    st_code = ST_BADSUM;
                    if (rx == SYNC_CODE)
                    begin
                        phase_next = PH_HEADER;
                        count_next = '0;
                        crc_next   = '0;
                    end
                end
            end
            default:
            begin
                phase_next = PH_SYNC;
            end
        endcase

        // Status and header view after the step
        if (st_forced)
        begin
            res.status = st_code;
        end
        else
        begin
            res.status = (phase_next == PH_SYNC) ? ST_HUNT : ST_BUSY;
        end
        res.data_length   = {hdr_next[0], hdr_next[1]};
        res.option_length = hdr_next[2];
        res.packet_type   = hdr_next[3];
    end

    // Output register handshake
    assign s_tready     = !m_valid_reg || m_tready;
    assign m_valid_next = in_fire ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    assign m_tvalid     = m_valid_reg;
    assign m_tdata      = result_reg;

    // Control and receiver state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            phase_reg    <= PH_SYNC;
            crc_reg      <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < HDR_LEN; i++)
            begin
                hdr_reg[i] <= '0;
            end
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                capacity_reg <= cfg_data;
            end
            if (in_fire)
            begin
                phase_reg <= phase_next;
                crc_reg   <= crc_next;
                count_reg <= count_next;
                hdr_reg   <= hdr_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            result_reg <= res;
        end
    end

    // Checks
    `ESP3_ASSERT_NEXT(a_fire_fills_out, in_fire, m_tvalid,
        "accepted item did not reach the output register")
    `ESP3_ASSERT_ALWAYS(a_store_in_progress,
        !(m_tvalid && result_reg.stored_valid) || (result_reg.status == ST_BUSY),
        "stored payload byte reported with a final status")
    `ESP3_ASSERT_ALWAYS(a_store_below_cap,
        !(m_tvalid && result_reg.stored_valid) || (result_reg.stored_index < capacity_reg),
        "payload byte stored beyond buffer capacity")
    `ESP3_ASSERT_NEXT(a_ok_returns_hunt, in_fire && (res.status == ST_OK),
        phase_reg == PH_SYNC, "good packet did not return to sync hunt")

endmodule

### test/tb_esp3_packet_receiver_top.sv
`timescale 1ns / 1ps

module tb_esp3_packet_receiver_top;
    import esp3_rx_pkg::*;

    localparam int ITEMS_PER_PHASE = 370;
    localparam int HOLD_CYCLES     = 60;
    localparam int DRAIN_CYCLES    = 4;

    // Directed rows: a literal byte, a header/data CRC picked from the running CRC,
    // a type byte that steers the header CRC to the sync code, or a capacity write
    typedef enum {RK_BYTE, RK_CRC_OK, RK_CRC_BAD, RK_TO_SYNC, RK_CAP} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [15:0] val;
        bit          typed;
        status_t     st;
    } dir_row_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;            // status, stored_valid/byte/index, header view
    logic        cfg_we   = 1'b0;
    logic [15:0] cfg_data = 16'h0000;

    // Deframer state as the predictor sees it
    phase_t      rx_phase = PH_SYNC;
    logic [7:0]  hdr_q [4] = '{default: 8'h00};
    logic [7:0]  crc_q    = 8'h00;
    logic [16:0] count_q  = 17'd0;
    logic [15:0] capacity = CAP_RESET;

    result_t     pending_results [$];

    int err_cnt      = 0;
    int bytes_sent   = 0;
    int results_seen = 0;
    int n_ok         = 0;
    int n_range      = 0;
    int n_badsum     = 0;
    int n_stored     = 0;
    int send_idle    = 0;
    int ready_stall  = 0;
    bit hold_req     = 1'b0;
    int hold_left    = 0;

    // Per phase: sender idle %, receiver stall %, capacity
    int          idle_plan  [5] = '{0, 65, 0, 25, 0};
    int          stall_plan [5] = '{0, 0, 65, 25, 0};
    logic [15:0] cap_plan   [5] = '{16'hFFFF, 16'd0, 16'd3, 16'd256, 16'd16};

    dir_row_t dir_rows [32] = '{
        '{RK_BYTE,    16'h00, 1'b1, ST_HUNT},    // after reset, noise
        '{RK_BYTE,    16'h55, 1'b1, ST_BUSY},    // sync
        '{RK_BYTE,    16'h00, 1'b0, ST_HUNT},
        '{RK_BYTE,    16'h00, 1'b0, ST_HUNT},
        '{RK_BYTE,    16'h00, 1'b0, ST_HUNT},
        '{RK_TO_SYNC, 16'h00, 1'b0, ST_HUNT},    // header CRC becomes 0x55
        '{RK_CRC_OK,  16'h00, 1'b1, ST_BUSY},    // zero length, CRC byte is sync
        '{RK_BYTE,    16'h00, 1'b0, ST_HUNT},
        '{RK_BYTE,    16'h00, 1'b0, ST_HUNT},
        '{RK_BYTE,    16'h00, 1'b0, ST_HUNT},
        '{RK_BYTE,    16'h00, 1'b0, ST_HUNT},
        '{RK_CRC_OK,  16'h00, 1'b1, ST_RANGE},   // zero length, plain CRC byte
        '{RK_BYTE,    16'h55, 1'b0, ST_HUNT},
        '{RK_BYTE,    16'h55, 1'b0, ST_HUNT},    // sync inside the header
        '{RK_BYTE,    16'h00, 1'b0, ST_HUNT},
        '{RK_BYTE,    16'h01, 1'b0, ST_HUNT},
        '{RK_BYTE,    16'h00, 1'b0, ST_HUNT},
        '{RK_CRC_BAD, 16'h00, 1'b1, ST_BUSY},    // realign, four bytes held
        '{RK_CRC_OK,  16'h00, 1'b1, ST_BUSY},
        '{RK_BYTE,    16'h00, 1'b0, ST_HUNT},    // one payload byte
        '{RK_BYTE,    16'h55, 1'b1, ST_BADSUM},  // bad data CRC that is sync
        '{RK_CAP,     16'h01, 1'b0, ST_HUNT},
        '{RK_BYTE,    16'h00, 1'b0, ST_HUNT},
        '{RK_BYTE,    16'h03, 1'b0, ST_HUNT},
        '{RK_BYTE,    16'h01, 1'b0, ST_HUNT},
        '{RK_BYTE,    16'h07, 1'b0, ST_HUNT},
        '{RK_CRC_OK,  16'h00, 1'b1, ST_BUSY},
        '{RK_BYTE,    16'h11, 1'b0, ST_HUNT},
        '{RK_BYTE,    16'h22, 1'b0, ST_HUNT},
        '{RK_BYTE,    16'h33, 1'b0, ST_HUNT},
        '{RK_BYTE,    16'hFF, 1'b0, ST_HUNT},
        '{RK_CRC_OK,  16'h00, 1'b1, ST_RANGE}    // payload past capacity
    };

    esp3_packet_receiver_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // CRC-8, poly 0x07, MSB first
    function automatic logic [7:0] crc8_step(logic [7:0] c, logic [7:0] d);
        logic [7:0] v;
        v = c ^ d;
        for (int b = 0; b < 8; b++)
        begin
            v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
        end
        return v;
    endfunction

    function void start_header();
        rx_phase = PH_HEADER;
        count_q  = 17'd0;
        crc_q    = 8'h00;
    endfunction

    // Advance the deframer by one received byte and return the result item
    function automatic result_t deframe_byte(input logic [7:0] rx);
        result_t     r;
        status_t     st;
        bit          decided;
        logic [16:0] total;
        int          skip;
        r       = '0;
        st      = ST_HUNT;
        decided = 1'b0;
        total   = {1'b0, hdr_q[0], hdr_q[1]} + hdr_q[2];
        case (rx_phase)
            PH_SYNC:
            begin
                if (rx == SYNC_CODE)
                begin
                    start_header();
                end
            end
            PH_HEADER:
            begin
                hdr_q[count_q[1:0]] = rx;
                crc_q   = crc8_step(crc_q, rx);
                count_q = count_q + 17'd1;
                if (count_q >= HDR_LEN)
                begin
                    rx_phase = PH_HCRC;
                end
            end
            PH_HCRC:
            begin
                if (crc_q != rx)
                begin
                    // bad header CRC: realign after the first sync byte, if any
                    skip = 0;
                    for (int i = 0; i < HDR_LEN; i++)
                    begin
                        if (skip == 0 && hdr_q[i] == SYNC_CODE)
                        begin
                            skip = i + 1;
                        end
                    end
                    if (skip == 0)
                    begin
                        if (rx == SYNC_CODE)
                        begin
                            start_header();
                        end
                        else
                        begin
                            rx_phase = PH_SYNC;
                        end
                    end
                    else
                    begin
                        crc_q = 8'h00;
                        for (int i = 0; i < HDR_LEN - skip; i++)
                        begin
                            hdr_q[i] = hdr_q[i + skip];
                            crc_q    = crc8_step(crc_q, hdr_q[i]);
                        end
                        hdr_q[HDR_LEN - skip] = rx;
                        crc_q    = crc8_step(crc_q, rx);
                        count_q  = 17'(HDR_LEN - skip + 1);
                        rx_phase = (count_q < HDR_LEN) ? PH_HEADER : PH_HCRC;
                    end
                end
                else if (total == 17'd0)
                begin
                    if (rx == SYNC_CODE)
                    begin
                        start_header();
                    end
                    else
                    begin
                        rx_phase = PH_SYNC;
                        st       = ST_RANGE;
                        decided  = 1'b1;
                    end
                end
                else
                begin
                    rx_phase = PH_DATA;
                    count_q  = 17'd0;
                    crc_q    = 8'h00;
                end
            end
            PH_DATA:
            begin
                if (count_q < capacity)
                begin
                    r.stored_valid = 1'b1;
                    r.stored_byte  = rx;
                    r.stored_index = count_q[15:0];
                    crc_q = crc8_step(crc_q, rx);
                end
                count_q = count_q + 17'd1;
                if (count_q == total)
                begin
                    rx_phase = PH_DCRC;
                end
            end
            PH_DCRC:
            begin
                rx_phase = PH_SYNC;
                decided  = 1'b1;
                if (count_q > capacity)
                begin
                    st = ST_RANGE;
                end
                else if (crc_q == rx)
                begin
                    st = ST_OK;
                end
                else
                begin
                    if (rx == SYNC_CODE)
                    begin
                        start_header();
                    end
                    st = ST_BADSUM;
                end
            end
            default:
            begin
                rx_phase = PH_SYNC;
            end
        endcase
        if (!decided)
        begin
            st = (rx_phase == PH_SYNC) ? ST_HUNT : ST_BUSY;
        end
        r.status        = st;
        r.data_length   = {hdr_q[0], hdr_q[1]};
        r.option_length = hdr_q[2];
        r.packet_type   = hdr_q[3];
        return r;
    endfunction

    // Offer one byte after a random gap; predict its result once accepted.
    // Entered and left at a falling edge.
    task automatic push_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input status_t st = ST_HUNT);
        result_t want;
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom_range(255));
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        want = deframe_byte(b);
        if (typed)
        begin
            want.status = st;
        end
        pending_results.push_back(want);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Capacity write once the block has drained
    task automatic set_capacity(input logic [15:0] value);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        capacity = value;
    endtask

    // One frame with random content; some noise, bad CRCs and sync bytes in the header
    task automatic send_frame();
        logic [15:0] dlen;
        logic [7:0]  olen;
        logic [7:0]  hcrc;
        logic [7:0]  hb [4];
        int          roll;
        int          pos;
        // finish a payload left over from a broken frame
        while (rx_phase == PH_DATA || rx_phase == PH_DCRC)
        begin
            push_byte(8'h00);
        end
        if ($urandom_range(99) < 8)
        begin
            repeat ($urandom_range(1, 6))
            begin
                push_byte(($urandom_range(2) == 0) ? SYNC_CODE : 8'($urandom_range(255)));
            end
            return;
        end
        roll = $urandom_range(99);
        if (roll < 5)
        begin
            dlen = 16'd0;
            olen = 8'd0;
        end
        else if (roll < 98)
        begin
            dlen = 16'($urandom_range(12));
            olen = 8'($urandom_range(6));
        end
        else
        begin
            dlen = 16'($urandom_range(13, 300));
            olen = 8'($urandom_range(255));
        end
        hb  = '{dlen[15:8], dlen[7:0], olen, 8'($urandom_range(255))};
        pos = -1;
        if ($urandom_range(9) == 0)
        begin
            pos     = $urandom_range(3);
            hb[pos] = SYNC_CODE;
        end
        push_byte(SYNC_CODE);
        foreach (hb[i])
        begin
            push_byte(hb[i]);
        end
        if (rx_phase != PH_HCRC)
        begin
            return;
        end
        // a sync byte in the length field always comes with a bad CRC
        if (pos == 0 || pos == 1 || $urandom_range(99) < 12)
        begin
            hcrc = crc_q ^ 8'($urandom_range(1, 255));
        end
        else
        begin
            hcrc = crc_q;
        end
        push_byte(hcrc);
        if (rx_phase != PH_DATA)
        begin
            return;
        end
        while (rx_phase == PH_DATA)
        begin
            push_byte(8'($urandom_range(255)));
        end
        roll = $urandom_range(99);
        push_byte((roll < 75) ? crc_q : (roll < 88) ? 8'($urandom_range(255)) : SYNC_CODE);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_cnt++;
        end
    endtask

    // Receiver: random stalls, plus long hold-offs on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= ready_stall);
        end
    end

    // Compare each result item with the oldest prediction
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata);
            if (pending_results.size() == 0)
            begin
                $error("result 0x%0h with no item pending", m_tdata);
                err_cnt++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_seen++;
                check_field("status", 16'(want.status), 16'(got.status));
                check_field("stored_valid", 16'(want.stored_valid), 16'(got.stored_valid));
                check_field("stored_byte", 16'(want.stored_byte), 16'(got.stored_byte));
                check_field("stored_index", want.stored_index, got.stored_index);
                check_field("data_length", want.data_length, got.data_length);
                check_field("option_length", 16'(want.option_length),
                            16'(got.option_length));
                check_field("packet_type", 16'(want.packet_type), 16'(got.packet_type));
                check_field("pad", 16'(want.pad), 16'(got.pad));
                case (want.status)
                    ST_OK:     n_ok++;
                    ST_RANGE:  n_range++;
                    ST_BADSUM: n_badsum++;
                    default:   ;
                endcase
                if (want.stored_valid)
                begin
                    n_stored++;
                end
            end
        end
    end

    initial
    begin
        logic [7:0] fill;
        int         phase_start;
        bit         paused;
        fill = 8'h00;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed rows
        foreach (dir_rows[i])
        begin
            case (dir_rows[i].kind)
                RK_BYTE:
                    push_byte(dir_rows[i].val[7:0], dir_rows[i].typed, dir_rows[i].st);
                RK_CRC_OK:
                    push_byte(crc_q, dir_rows[i].typed, dir_rows[i].st);
                RK_CRC_BAD:
                    push_byte(((crc_q ^ 8'h01) == SYNC_CODE) ? (crc_q ^ 8'h02)
                                                             : (crc_q ^ 8'h01),
                              dir_rows[i].typed, dir_rows[i].st);
                RK_TO_SYNC:
                begin
                    for (int d = 0; d < 256; d++)
                    begin
                        if (crc8_step(crc_q, 8'(d)) == SYNC_CODE)
                        begin
                            fill = 8'(d);
                        end
                    end
                    push_byte(fill, dir_rows[i].typed, dir_rows[i].st);
                end
                RK_CAP:
                    set_capacity(dir_rows[i].val);
                default:
                    ;
            endcase
        end

        // Random phases with different idling and capacities
        for (int p = 0; p < 5; p++)
        begin
            set_capacity(cap_plan[p]);
            send_idle   = idle_plan[p];
            ready_stall = stall_plan[p];
            if (p == 4)
            begin
                hold_req = 1'b1;
            end
            phase_start = bytes_sent;
            paused      = 1'b0;
            while (bytes_sent - phase_start < ITEMS_PER_PHASE)
            begin
                send_frame();
                if (p == 4 && !paused && bytes_sent - phase_start > ITEMS_PER_PHASE / 2)
                begin
                    // let the block drain completely, then hold the output again
                    paused = 1'b1;
                    s_tvalid <= 1'b0;
                    while (pending_results.size() != 0)
                    begin
                        @(negedge clk);
                    end
                    hold_req = 1'b1;
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("tb: %0d bytes deframed, %0d results compared, %0d payload bytes stored",
                 bytes_sent, results_seen, n_stored);
        $display("tb: packets ok %0d, out of range %0d, bad checksum %0d, capacity 0..65535",
                 n_ok, n_range, n_badsum);
        if (err_cnt == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #(20_000_000);
        $display("tb: failure");
        $finish;
    end

endmodule
